>>> rtl/sad_pkg.sv
// ---------------------------------------------------------------------------
// sad_pkg: shared types and constants for sort_and_dedupe
// Sizes of the cell chain, stream payload widths and the cell entry type.
// ---------------------------------------------------------------------------
package sad_pkg;

  localparam int unsigned MAX_ITEMS  = 64;
  localparam int unsigned VALUE_BITS = 10;

  // distinct_count field width is fixed at 7 bits
  localparam int unsigned COUNT_BITS = 7;
  localparam int unsigned CNT_W      = $clog2(MAX_ITEMS + 1);
  localparam int unsigned FILL_W     = $clog2(MAX_ITEMS + 1);

  // stream payload widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = ((VALUE_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_FLD_W   = VALUE_BITS + COUNT_BITS;
  localparam int unsigned OUT_TDATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  // fill-pulse reduction: groups of eight cells
  localparam int unsigned GRP_SIZE = 8;
  localparam int unsigned NUM_GRP  = (MAX_ITEMS + GRP_SIZE - 1) / GRP_SIZE;

  // cycles to wait after the last item so that every token has landed
  // and the distinct counter has caught up
  localparam int unsigned SETTLE_CYC = MAX_ITEMS + 4;
  localparam int unsigned SETTLE_W   = $clog2(SETTLE_CYC + 1);

  // one stored or travelling value
  typedef struct packed {
    logic                  vld;
    logic [VALUE_BITS-1:0] val;
  } entry_t;

endpackage

>>> rtl/sad_cell.sv
// ---------------------------------------------------------------------------
// sad_cell: one insertion cell of the sorting chain
// Keeps the smaller of held and incoming value, passes the larger right,
// drops an incoming value equal to the held one; shifts left on drain.
// ---------------------------------------------------------------------------
module sad_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sad_pkg::entry_t tok_i,    // token from the left neighbor
  output sad_pkg::entry_t tok_o,    // token to the right neighbor
  input  logic            shift_i,  // drain: take the right neighbor's entry
  input  sad_pkg::entry_t nbr_i,    // right neighbor's held entry
  output sad_pkg::entry_t ent_o,    // held entry
  output logic            fill_o    // an empty cell took a value this cycle
);

  sad_pkg::entry_t ent_q, ent_d;
  sad_pkg::entry_t tok_q, tok_d;

  always_comb begin
    ent_d     = ent_q;
    tok_d.vld = 1'b0;
    tok_d.val = tok_i.val;
    fill_o    = 1'b0;
    if (shift_i) begin
      ent_d = nbr_i;
    end else if (tok_i.vld) begin
      if (!ent_q.vld) begin
        ent_d.vld = 1'b1;
        ent_d.val = tok_i.val;
        fill_o    = 1'b1;
      end else if (tok_i.val < ent_q.val) begin
        // new value goes here, displaced one moves on
        ent_d.val = tok_i.val;
        tok_d.vld = 1'b1;
        tok_d.val = ent_q.val;
      end else if (tok_i.val > ent_q.val) begin
        tok_d.vld = 1'b1;
      end
      // equal: duplicate, dropped
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
      tok_q <= '0;
    end else begin
      ent_q <= ent_d;
      tok_q <= tok_d;
    end
  end

  assign ent_o = ent_q;
  assign tok_o = tok_q;

endmodule

>>> rtl/sad_count.sv
// ---------------------------------------------------------------------------
// sad_count: distinct value counter
// Registered OR tree over the per-cell fill pulses; at most one cell fills
// per cycle, so the counter steps by one when any pulse is seen.
// ---------------------------------------------------------------------------
module sad_count (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [sad_pkg::MAX_ITEMS-1:0] fill_i,
  input  logic                          clr_i,
  output logic [sad_pkg::CNT_W-1:0]     count_o
);

  localparam int unsigned PAD_W = sad_pkg::NUM_GRP * sad_pkg::GRP_SIZE;

  logic [PAD_W-1:0]            fill_q;
  logic [PAD_W-1:0]            fill_d;
  logic [sad_pkg::NUM_GRP-1:0] grp_q, grp_d;
  logic [sad_pkg::CNT_W-1:0]   cnt_q, cnt_d;

  always_comb begin
    fill_d = '0;
    fill_d[sad_pkg::MAX_ITEMS-1:0] = fill_i;
    for (int g = 0; g < sad_pkg::NUM_GRP; g++) begin
      grp_d[g] = |fill_q[g*sad_pkg::GRP_SIZE +: sad_pkg::GRP_SIZE];
    end
    if (clr_i) begin
      cnt_d = '0;
    end else begin
      cnt_d = cnt_q + sad_pkg::CNT_W'(|grp_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      grp_q  <= '0;
      cnt_q  <= '0;
    end else begin
      fill_q <= fill_d;
      grp_q  <= grp_d;
      cnt_q  <= cnt_d;
    end
  end

  assign count_o = cnt_q;

endmodule

>>> rtl/sort_and_dedupe_top.sv
// ---------------------------------------------------------------------------
// sort_and_dedupe_top: streaming sort with duplicate removal
// Loads a set of values, then emits each distinct value once, ascending.
// ---------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata[9:0] sample_value,
//                                           tlast last_item
//  m_axis    out  m_axis_tvalid/tready      tdata[9:0] distinct_value,
//                                           tdata[16:10] distinct_count,
//                                           tlast last_result, tuser overflow
//
//  Load: one item per cycle. Each value enters a chain of MAX_ITEMS
//  insertion cells and ripples right one cell per cycle.
//  After the item with tlast the chain settles in ST_SETTLE so that every
//  token has landed and the distinct counter has caught up.
//  Drain: one result per cycle out of cell 0 while m_axis_tready is high;
//  the chain shifts left on each accepted result. s_axis_tready is low
//  from last item to last result. Reset clears every cell, counter and
//  state; no clearing pass.
// ---------------------------------------------------------------------------
module sort_and_dedupe_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [sad_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [9:0] sample_value
  input  logic                            s_axis_tlast,   // last_item
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [sad_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // distinct_value,
                                                          // distinct_count
  output logic                            m_axis_tlast,   // last_result
  output logic                            m_axis_tuser    // overflow
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SETTLE,
    ST_DRAIN
  } state_e;

  state_e                        state_q, state_d;
  logic [sad_pkg::FILL_W-1:0]    fill_q, fill_d;      // items stored this set
  logic                          ovf_q, ovf_d;        // an item was dropped
  logic [sad_pkg::SETTLE_W-1:0]  settle_q, settle_d;

  sad_pkg::entry_t               tok [sad_pkg::MAX_ITEMS];
  sad_pkg::entry_t               ent [sad_pkg::MAX_ITEMS];
  logic [sad_pkg::MAX_ITEMS-1:0] fill_pulse;
  logic [sad_pkg::CNT_W-1:0]     count;

  logic in_acc, out_acc, shift, room, clr;

  assign s_axis_tready = (state_q == ST_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign room          = (fill_q < sad_pkg::FILL_W'(sad_pkg::MAX_ITEMS));

  // drain from cell 0; cells form a valid prefix once settled
  assign m_axis_tvalid = (state_q == ST_DRAIN) && ent[0].vld;
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign shift         = out_acc;
  assign m_axis_tlast  = !ent[1].vld;
  assign m_axis_tuser  = ovf_q;
  assign clr           = out_acc && m_axis_tlast;

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[sad_pkg::VALUE_BITS-1:0] = ent[0].val;
    m_axis_tdata[sad_pkg::VALUE_BITS +: sad_pkg::COUNT_BITS] =
      sad_pkg::COUNT_BITS'(count);
  end

  // new token into cell 0 when the item is stored
  assign tok[0].vld = in_acc && room;
  assign tok[0].val = s_axis_tdata[sad_pkg::VALUE_BITS-1:0];

  for (genvar i = 0; i < sad_pkg::MAX_ITEMS; i++) begin : g_cell
    if (i == sad_pkg::MAX_ITEMS - 1) begin : g_tail
      // never more distinct values than cells: tail token goes nowhere
      sad_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .tok_i   (tok[i]),
        .tok_o   (),
        .shift_i (shift),
        .nbr_i   ('0),
        .ent_o   (ent[i]),
        .fill_o  (fill_pulse[i])
      );
    end else begin : g_body
      sad_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .tok_i   (tok[i]),
        .tok_o   (tok[i+1]),
        .shift_i (shift),
        .nbr_i   (ent[i+1]),
        .ent_o   (ent[i]),
        .fill_o  (fill_pulse[i])
      );
    end
  end

  sad_count u_count (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fill_i  (fill_pulse),
    .clr_i   (clr),
    .count_o (count)
  );

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    ovf_d    = ovf_q;
    settle_d = settle_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (room) begin
            fill_d = fill_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            state_d  = ST_SETTLE;
            settle_d = '0;
          end
        end
      end
      ST_SETTLE: begin
        settle_d = settle_q + 1'b1;
        if (settle_q == sad_pkg::SETTLE_W'(sad_pkg::SETTLE_CYC - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (clr) begin
          state_d = ST_LOAD;
          fill_d  = '0;
          ovf_d   = 1'b0;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      fill_q   <= '0;
      ovf_q    <= 1'b0;
      settle_q <= '0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      ovf_q    <= ovf_d;
      settle_q <= settle_d;
    end
  end

endmodule

>>> rtl/sad_checker.sv
// ---------------------------------------------------------------------------
// sad_port_checker: port-level checks for sort_and_dedupe_top
// Watches both streams over time; attached to the top level by bind.
// ---------------------------------------------------------------------------
module sad_port_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [sad_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast,
  input logic                            m_axis_tuser
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // loading and draining never overlap
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while results pending");

  // results of a run come back to back in strictly ascending order
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && (m_axis_tdata[sad_pkg::VALUE_BITS-1:0] >
                        $past(m_axis_tdata[sad_pkg::VALUE_BITS-1:0])))
    else $error("results not strictly ascending");

  // a run ends with the input side open again
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=>
      !m_axis_tvalid && s_axis_tready)
    else $error("no return to load after last result");

  // count is never zero while a result is shown
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[sad_pkg::VALUE_BITS +: sad_pkg::COUNT_BITS] != '0))
    else $error("zero distinct count on a result");

  // input valid is only observed
  logic unused_in;
  assign unused_in = s_axis_tvalid;

endmodule

bind sort_and_dedupe_top sad_port_checker u_port_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
